FILE: src/ssr_pkg.sv
// Shared types, constants and helpers for the stream substring replace block.
// Used by every module under src; depends on nothing.
package ssr_pkg;

  localparam int PATTERN_MAX     = 8;
  localparam int REPLACEMENT_MAX = 8;
  localparam int CHAR_W          = 8;
  localparam int WORD_CHARS      = 8;               // characters per config register
  localparam int WORD_W          = CHAR_W * WORD_CHARS;
  localparam int LEN_W           = 4;
  localparam int IDX_W           = $clog2(WORD_CHARS);
  localparam int PLEN_CAP        = (PATTERN_MAX < WORD_CHARS) ? PATTERN_MAX : WORD_CHARS;
  localparam int RLEN_CAP        = (REPLACEMENT_MAX < WORD_CHARS) ? REPLACEMENT_MAX : WORD_CHARS;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_e;

  // One unit of output work: send count characters from chars, low byte first.
  // count == 0 with last set is a bare end marker.
  typedef struct packed {
    logic [WORD_W-1:0] chars;
    logic [LEN_W-1:0]  count;
    logic              last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                 input int cap);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(cap);
    return (len > lim) ? lim : len;
  endfunction

  function automatic logic [WORD_W-1:0] char_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int k = 0; k < WORD_CHARS; k++) begin
      if (LEN_W'(k) < len) m[k*CHAR_W +: CHAR_W] = '1;
    end
    return m;
  endfunction

endpackage

FILE: src/ssr_front.sv
// Front end: configuration registers, match window and job classification.
// Depends on ssr_pkg.
module ssr_front import ssr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    in_byte,
  input  logic                 in_last,
  input  queue_stat_t          q_stat,
  output logic                 push,
  output job_t                 job
);

  logic [WORD_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic [WORD_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]  replacement_length;

  logic [WORD_W-1:0] win, win_next;
  logic [LEN_W-1:0]  fill, fill_next;

  logic [LEN_W-1:0]  plen, rlen, fill_app;
  logic [WORD_W-1:0] win_app;
  logic              accept, full, match, len_wr;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign len_wr   = cfg_wr_en && (cfg_reg_e'(cfg_index) == REG_PATTERN_LENGTH);
  assign plen     = clamp_len(pattern_length, PLEN_CAP);
  assign rlen     = clamp_len(replacement_length, RLEN_CAP);
  assign fill_app = fill + LEN_W'(1);
  assign full     = (fill_app == plen);
  assign match    = full && (((win_app ^ pattern_bytes) & char_mask(plen)) == '0);

  always_comb begin
    win_app = win;
    for (int k = 0; k < WORD_CHARS; k++) begin
      if (fill[IDX_W-1:0] == IDX_W'(k)) win_app[k*CHAR_W +: CHAR_W] = in_byte;
    end
  end

  always_comb begin
    win_next   = win_app;
    fill_next  = fill_app;
    job.chars  = win_app;
    job.count  = fill_app;
    job.last   = in_last;
    if (plen == '0) begin
      // pass-through
      win_next  = win;
      fill_next = '0;
      job.chars = {{(WORD_W-CHAR_W){1'b0}}, in_byte};
      job.count = LEN_W'(1);
    end else if (match) begin
      fill_next = '0;
      job.chars = replacement_bytes;
      job.count = rlen;
    end else if (in_last) begin
      fill_next = '0;
    end else if (full) begin
      // oldest character leaves, window slides down one
      win_next  = win_app >> CHAR_W;
      fill_next = fill;
      job.count = LEN_W'(1);
    end else begin
      job.count = '0;
    end
    if (in_last) fill_next = '0;
  end

  assign push = accept && ((job.count != '0) || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      fill               <= '0;
    end else begin
      // a pattern length write empties the window
      if (len_wr) begin
        fill <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (cfg_wr_en) begin
        case (cfg_reg_e'(cfg_index))
          REG_PATTERN_BYTES:      pattern_bytes <= cfg_data;
          REG_PATTERN_LENGTH:     pattern_length <= cfg_data[LEN_W-1:0];
          REG_REPLACEMENT_BYTES:  replacement_bytes <= cfg_data;
          REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) win <= win_next;
  end

endmodule

FILE: src/ssr_queue.sv
// Small job queue between front and back end.
// Depends on ssr_pkg.
module ssr_queue import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        head,
  output queue_stat_t stat
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      cnt <= cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

endmodule

FILE: src/ssr_back.sv
// Back end: walks the head job one character a beat into the output register.
// Depends on ssr_pkg.
module ssr_back import ssr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  job_t              head,
  input  queue_stat_t       q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_byte,
  output logic              byte_valid,
  output logic              run_last,
  output logic              text_end
);

  logic [IDX_W-1:0] idx;
  logic             emit, job_done, has_char;

  assign has_char = (head.count != '0);
  assign emit     = !q_stat.empty && (!out_valid || out_ready);
  assign job_done = !has_char || ((LEN_W'(idx) + LEN_W'(1)) == head.count);
  assign pop      = emit && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= job_done ? '0 : idx + IDX_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= has_char ? head.chars[idx*CHAR_W +: CHAR_W] : '0;
      byte_valid <= has_char;
      run_last   <= job_done;
      text_end   <= job_done && head.last;
    end
  end

endmodule

FILE: src/stream_substring_replace.sv
// Top level of the streaming find-and-replace block.
// Depends on ssr_pkg, ssr_front, ssr_queue and ssr_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): one text character a beat, in_last
//    marks the final character of the text.
//  - Output channel (out_valid/out_ready): one result a beat. byte_valid is
//    low only on a bare end marker; run_last closes the results of one input
//    beat, text_end closes the whole text.
//  - Config port: write pattern/replacement words and lengths with cfg_wr_en
//    while the block is idle. Writing the pattern length empties the window.
//  - Path: a result is queued at the edge that accepts the input beat that
//    caused it, and is loaded into the output register from the queue head
//    once the output register is free and the jobs ahead of it are sent.
//  - Throughput: one input beat a cycle while out_ready stays high and each
//    beat yields at most one character. The back end sends one character a
//    cycle unless stalled, so a match with an n-character replacement, or a
//    window flush of n characters at text end, busies it for n characters;
//    the four-entry job queue absorbs that and in_ready drops only when full.
//  - Stall: when out_ready is low the output register holds, the back end
//    stops, and the front keeps taking beats until the queue is full.
//  - Reset: synchronous, clears the config registers, the window and the queue.
module stream_substring_replace import ssr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    in_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAR_W-1:0]    out_byte,
  output logic                 byte_valid,
  output logic                 run_last,
  output logic                 text_end
);

  queue_stat_t q_stat;
  job_t        push_job, head;
  logic        push, pop;

  // window, match and classification
  ssr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  // decouples expansion on the back from intake on the front
  ssr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // serializer and output register
  ssr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end)
  );

endmodule

FILE: src/ssr_checker.sv
// Port-level checks for stream_substring_replace, attached by bind.
// Depends on ssr_pkg.
module ssr_checker import ssr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_byte,
  input logic              byte_valid,
  input logic              run_last,
  input logic              text_end
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(run_last) && $stable(text_end))
    else $error("output beat changed while stalled");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> run_last)
    else $error("text end without run end");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> run_last && text_end && (out_byte == '0))
    else $error("bare marker not a clean text end");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .run_last   (run_last),
  .text_end   (text_end)
);
